// ===== hdl/sha256_message_hasher_defines.svh =====
// ----------------------------------------------------------------------------
// SHA-256 message hasher assertion macros
// Shared property forms for the checker of the message hasher.
// ----------------------------------------------------------------------------
`ifndef SHA256_MESSAGE_HASHER_DEFINES_SVH
`define SHA256_MESSAGE_HASHER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHA_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SHA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Word types, controller states, datapath commands and hash constants.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } sha256_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha256_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_PAD_ONE,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_EMIT
  } sha256_state_e;

  typedef enum logic [1:0] {
    BSEL_DATA,
    BSEL_PAD,
    BSEL_ZERO,
    BSEL_LEN
  } sha256_bsel_e;

  typedef struct packed {
    logic         shift_en;
    sha256_bsel_e byte_sel;
    logic         load_work;
    logic         round_en;
    logic [5:0]   round_idx;
    logic         final_add;
    logic         init_hash;
    logic [2:0]   word_idx;
  } sha256_cmd_t;

  localparam logic [7:0] PadByte   = 8'h80;
  localparam logic [5:0] LenStart  = 6'd55;
  localparam logic [5:0] LastSlot  = 6'd63;
  localparam logic [5:0] LastRound = 6'd63;
  localparam logic [2:0] LastWord  = 3'd7;

  // Element 0 is the first hash word.
  localparam logic [7:0][31:0] InitHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic logic [31:0] round_const(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

// ===== hdl/sha256_ctrl.sv =====
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte intake, padding, the 64 rounds and digest emission.
// ----------------------------------------------------------------------------
module sha256_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_byte_present_i,
  input  logic                     in_end_i,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output sha256_pkg::sha256_cmd_t  cmd_o
);
  import sha256_pkg::*;

  sha256_state_e state_q, state_d;
  logic [5:0]    fill_q, fill_d;
  logic [5:0]    round_q, round_d;
  logic [2:0]    word_q, word_d;
  logic          pend_end_q, pend_end_d;
  logic          pad_q, pad_d;
  logic          last_q, last_d;
  logic          in_acc, out_acc, fill_full;

  assign in_acc    = in_valid_i && (state_q == ST_IDLE);
  assign out_acc   = (state_q == ST_EMIT) && !out_stall_i;
  assign fill_full = (fill_q == LastSlot);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_byte_present_i && fill_full) state_d = ST_ROUND;
          else if (in_end_i)                  state_d = ST_PAD_ONE;
        end
      end
      ST_ROUND: begin
        if (round_q == LastRound) state_d = ST_FINAL;
      end
      ST_FINAL: begin
        if (last_q)          state_d = ST_EMIT;
        else if (pend_end_q) state_d = ST_PAD_ONE;
        else if (pad_q)      state_d = ST_PAD_ZERO;
        else                 state_d = ST_IDLE;
      end
      ST_PAD_ONE: begin
        if (fill_full)                state_d = ST_ROUND;
        else if (fill_q == LenStart)  state_d = ST_PAD_LEN;
        else                          state_d = ST_PAD_ZERO;
      end
      ST_PAD_ZERO: begin
        if (fill_full)               state_d = ST_ROUND;
        else if (fill_q == LenStart) state_d = ST_PAD_LEN;
      end
      ST_PAD_LEN: begin
        if (fill_full) state_d = ST_ROUND;
      end
      ST_EMIT: begin
        if (out_acc && (word_q == LastWord)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.byte_sel  = BSEL_DATA;
    cmd_o.round_idx = round_q;
    cmd_o.word_idx  = word_q;
    in_stall_o      = (state_q != ST_IDLE);
    out_valid_o     = (state_q == ST_EMIT);
    fill_d          = fill_q;
    round_d         = round_q;
    word_d          = word_q;
    pend_end_d      = pend_end_q;
    pad_d           = pad_q;
    last_d          = last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && in_byte_present_i) begin
          cmd_o.shift_en = 1'b1;
          fill_d         = fill_q + 6'd1;
          if (fill_full) begin
            cmd_o.load_work = 1'b1;
            pend_end_d      = in_end_i;
          end
        end
      end
      ST_ROUND: begin
        cmd_o.round_en = 1'b1;
        round_d        = round_q + 6'd1;
      end
      ST_FINAL: begin
        cmd_o.final_add = 1'b1;
        if (!last_q) pend_end_d = 1'b0;
      end
      ST_PAD_ONE: begin
        cmd_o.shift_en  = 1'b1;
        cmd_o.byte_sel  = BSEL_PAD;
        cmd_o.load_work = fill_full;
        fill_d          = fill_q + 6'd1;
        pad_d           = 1'b1;
      end
      ST_PAD_ZERO: begin
        cmd_o.shift_en  = 1'b1;
        cmd_o.byte_sel  = BSEL_ZERO;
        cmd_o.load_work = fill_full;
        fill_d          = fill_q + 6'd1;
      end
      ST_PAD_LEN: begin
        cmd_o.shift_en  = 1'b1;
        cmd_o.byte_sel  = BSEL_LEN;
        cmd_o.load_work = fill_full;
        fill_d          = fill_q + 6'd1;
        if (fill_full) last_d = 1'b1;
      end
      ST_EMIT: begin
        if (out_acc) begin
          word_d = word_q + 3'd1;
          if (word_q == LastWord) begin
            cmd_o.init_hash = 1'b1;
            pad_d           = 1'b0;
            last_d          = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fill_q     <= '0;
      round_q    <= '0;
      word_q     <= '0;
      pend_end_q <= 1'b0;
      pad_q      <= 1'b0;
      last_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      round_q    <= round_d;
      word_q     <= word_d;
      pend_end_q <= pend_end_d;
      pad_q      <= pad_d;
      last_q     <= last_d;
    end
  end

endmodule

// ===== hdl/sha256_datapath.sv =====
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block window with message schedule, round logic, hash and length registers.
// ----------------------------------------------------------------------------
module sha256_datapath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sha256_pkg::sha256_cmd_t  cmd_i,
  input  logic [7:0]               data_byte_i,
  output sha256_pkg::sha256_out_t  out_data_o
);
  import sha256_pkg::*;

  function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned s);
    return (v >> s) | (v << (32 - s));
  endfunction

  // The window holds 64 bytes, first byte in the top bits; word 0 is the top.
  logic [511:0]      win_q, win_d;
  logic [63:0]       len_q, len_d;
  logic [7:0][31:0]  hash_q, hash_d;
  logic [7:0][31:0]  work_q, work_d;
  logic [7:0]        byte_in;
  logic [31:0]       w0, w1, w9, w14, w_new, sig0, sig1;
  logic [31:0]       big0, big1, ch, maj, t1, t2;

  always_comb begin
    unique case (cmd_i.byte_sel)
      BSEL_DATA: byte_in = data_byte_i;
      BSEL_PAD:  byte_in = PadByte;
      BSEL_ZERO: byte_in = 8'h00;
      BSEL_LEN:  byte_in = len_q[63:56];
      default:   byte_in = 8'h00;
    endcase
  end

  assign w0    = win_q[511:480];
  assign w1    = win_q[479:448];
  assign w9    = win_q[223:192];
  assign w14   = win_q[63:32];
  assign sig0  = ror(w1, 7) ^ ror(w1, 18) ^ (w1 >> 3);
  assign sig1  = ror(w14, 17) ^ ror(w14, 19) ^ (w14 >> 10);
  assign w_new = w0 + sig0 + w9 + sig1;

  assign big1 = ror(work_q[4], 6) ^ ror(work_q[4], 11) ^ ror(work_q[4], 25);
  assign ch   = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
  assign t1   = work_q[7] + big1 + ch + round_const(cmd_i.round_idx) + w0;
  assign big0 = ror(work_q[0], 2) ^ ror(work_q[0], 13) ^ ror(work_q[0], 22);
  assign maj  = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^
                (work_q[1] & work_q[2]);
  assign t2   = big0 + maj;

  always_comb begin
    win_d = win_q;
    if (cmd_i.shift_en)      win_d = {win_q[503:0], byte_in};
    else if (cmd_i.round_en) win_d = {win_q[479:0], w_new};

    len_d = len_q;
    if (cmd_i.init_hash) begin
      len_d = '0;
    end else if (cmd_i.shift_en && (cmd_i.byte_sel == BSEL_DATA)) begin
      len_d = len_q + 64'd8;
    end else if (cmd_i.shift_en && (cmd_i.byte_sel == BSEL_LEN)) begin
      len_d = {len_q[55:0], 8'h00};
    end

    work_d = work_q;
    if (cmd_i.load_work) begin
      work_d = hash_q;
    end else if (cmd_i.round_en) begin
      work_d[7] = work_q[6];
      work_d[6] = work_q[5];
      work_d[5] = work_q[4];
      work_d[4] = work_q[3] + t1;
      work_d[3] = work_q[2];
      work_d[2] = work_q[1];
      work_d[1] = work_q[0];
      work_d[0] = t1 + t2;
    end

    hash_d = hash_q;
    if (cmd_i.final_add) begin
      for (int i = 0; i < 8; i++) hash_d[i] = hash_q[i] + work_q[i];
    end else if (cmd_i.init_hash) begin
      hash_d = InitHash;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q  <= win_d;
    work_q <= work_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      hash_q <= InitHash;
    end else begin
      len_q  <= len_d;
      hash_q <= hash_d;
    end
  end

  assign out_data_o.digest_word = hash_q[cmd_i.word_idx];
  assign out_data_o.word_index  = cmd_i.word_idx;
  assign out_data_o.last_word   = (cmd_i.word_idx == LastWord);

endmodule

// ===== hdl/sha256_message_hasher.sv =====
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Hashes a byte stream per message and returns the eight digest words.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake               Word
//   in       input      in_valid_i / in_stall_o   sha256_in_t (byte and flags)
//   out      output     out_valid_o / out_stall_i sha256_out_t (one digest word)
//
// A plain message byte is taken while the controller is idle. The byte that
// fills a 64-byte block starts the compression, which runs one round per
// cycle and then adds the working variables into the hash words. The end of
// a message adds the padding bytes, one or two more compressions, and the
// eight digest words of output.
// Reset loads the initial hash values and clears the bit count; the input
// stalls whenever the block is compressing, padding or returning a digest.
//
// The design splits into a controller, which owns the state machine, the
// fill count of the block window, the round counter and the digest word
// counter, and a datapath, which holds the 512-bit window that doubles as
// the message schedule, the working variables, the hash words and the
// 64-bit bit count. The window shifts in bytes during intake and shifts by
// one word per round during compression, so the schedule needs only fixed
// taps. Digest words are read straight from the hash registers, which hold
// still until the last word is taken; the input side stays stalled until then.
//
module sha256_message_hasher (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  sha256_pkg::sha256_in_t   in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output sha256_pkg::sha256_out_t  out_data_o
);
  import sha256_pkg::*;

  sha256_cmd_t cmd;

  // The controller decides every step; the datapath only follows commands.
  sha256_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_byte_present_i (in_data_i.byte_present),
    .in_end_i          (in_data_i.end_of_message),
    .in_stall_o        (in_stall_o),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .cmd_o             (cmd)
  );

  sha256_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .data_byte_i (in_data_i.data_byte),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hdl/sha256_checker.sv =====
// ----------------------------------------------------------------------------
// SHA-256 message hasher checker
// Port-level properties of the digest output sequence.
// ----------------------------------------------------------------------------
`include "sha256_message_hasher_defines.svh"

module sha256_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input sha256_pkg::sha256_in_t   in_data_i,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input sha256_pkg::sha256_out_t  out_data_o
);
  import sha256_pkg::*;

  logic out_acc;
  logic in_seen;

  assign out_acc = out_valid_o && !out_stall_i;
  assign in_seen = in_valid_i && in_data_i.end_of_message;

  // A stalled digest word stays put.
  `SHA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "digest word changed while stalled")

  // No input is taken while a digest is being returned.
  `SHA_ASSERT_SAME(a_no_in_during_out, clk_i, rst_ni, out_valid_o, in_stall_o, "input accepted during digest output")

  // Words come out in order without gaps.
  `SHA_ASSERT_NEXT(a_word_order, clk_i, rst_ni, out_acc && !out_data_o.last_word, out_valid_o && (out_data_o.word_index == $past(out_data_o.word_index) + 3'd1), "digest word order broken")

  // The flag marks exactly the eighth word.
  `SHA_ASSERT_SAME(a_last_flag, clk_i, rst_ni, out_valid_o, out_data_o.last_word == (out_data_o.word_index == LastWord), "last word flag mismatch")

  // After the last word the output goes quiet and input reopens.
  `SHA_ASSERT_NEXT(a_end_of_digest, clk_i, rst_ni, out_acc && out_data_o.last_word, !out_valid_o && !in_stall_o, "digest did not finish cleanly")

  logic unused_in;
  assign unused_in = in_seen ^ (^in_data_i.data_byte) ^ in_data_i.byte_present;

endmodule

bind sha256_message_hasher sha256_checker u_checker (.*);

// ===== verif/sha256_message_hasher_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message hasher checker
// Watches both channels, computes each message digest with its own SHA-256
// implementation and compares every digest word the hasher returns.
// ----------------------------------------------------------------------------
module sha256_message_hasher_checker (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  sha256_pkg::sha256_in_t  in_data_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  sha256_pkg::sha256_out_t out_data_i,
  output int unsigned             words_pending_o,
  output int unsigned             fail_count_o
);

  import sha256_pkg::*;

  // Listed in round order, so round t sits at index 63 - t.
  localparam logic [63:0][31:0] RoundK = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Listed from the first hash word, so word j sits at index 7 - j.
  localparam logic [7:0][31:0] StartHash = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic [31:0]  hash_q [8];
  logic [7:0]   block_q [64];
  logic [63:0]  bit_count_q;
  int unsigned  fill_q;
  sha256_out_t  digest_words_q [$];
  int unsigned  mismatches;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] s0, s1, wt, t1, t2, w15, w2;
    for (int j = 0; j < 16; j++) begin
      w[j] = {block_q[4*j], block_q[4*j+1], block_q[4*j+2], block_q[4*j+3]};
    end
    for (int j = 0; j < 8; j++) v[j] = hash_q[j];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        // The schedule lives in a 16-word ring; slot t%16 holds W[t-16].
        w15 = w[(t - 15) % 16];
        w2  = w[(t - 2) % 16];
        s0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
        s1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
        wt = w[t % 16] + s0 + w[(t - 7) % 16] + s1;
        w[t % 16] = wt;
      end
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[63 - t] + wt;
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) hash_q[j] = hash_q[j] + v[j];
  endfunction

  function automatic void restart_message();
    for (int j = 0; j < 8; j++) hash_q[j] = StartHash[7 - j];
    bit_count_q = '0;
    fill_q = 0;
  endfunction

  // Absorbs one accepted word and, on the end of a message, pads, finishes
  // the hash and queues the eight digest words.
  function automatic void absorb_word(input sha256_in_t word);
    sha256_out_t queued;
    if (word.byte_present) begin
      block_q[fill_q] = word.data_byte;
      fill_q++;
      bit_count_q = bit_count_q + 64'd8;
      if (fill_q == 64) begin
        compress_block();
        fill_q = 0;
      end
    end
    if (word.end_of_message) begin
      block_q[fill_q] = 8'h80;
      fill_q++;
      // No room for the length field: close this block and pad a fresh one.
      if (fill_q > 56) begin
        while (fill_q < 64) begin
          block_q[fill_q] = 8'h00;
          fill_q++;
        end
        compress_block();
        fill_q = 0;
      end
      while (fill_q < 56) begin
        block_q[fill_q] = 8'h00;
        fill_q++;
      end
      for (int j = 0; j < 8; j++) block_q[56 + j] = bit_count_q[63 - 8*j -: 8];
      compress_block();
      for (int j = 0; j < 8; j++) begin
        queued = '{digest_word: hash_q[j], word_index: 3'(j), last_word: (j == 7)};
        digest_words_q = {digest_words_q, queued};
      end
      restart_message();
    end
  endfunction

  function automatic void check_digest_word(input sha256_out_t got);
    sha256_out_t exp;
    if (digest_words_q.size() == 0) begin
      $error("digest word %h arrived with no digest outstanding", got.digest_word);
      mismatches++;
      return;
    end
    exp = digest_words_q.pop_front();
    if (got.digest_word !== exp.digest_word) begin
      $error("digest_word: expected %h, got %h", exp.digest_word, got.digest_word);
      mismatches++;
    end
    if (got.word_index !== exp.word_index) begin
      $error("word_index: expected %0d, got %0d", exp.word_index, got.word_index);
      mismatches++;
    end
    if (got.last_word !== exp.last_word) begin
      $error("last_word: expected %b, got %b", exp.last_word, got.last_word);
      mismatches++;
    end
  endfunction

  initial mismatches = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_message();
      for (int j = 0; j < 64; j++) block_q[j] = 8'h00;
      digest_words_q.delete();
    end else begin
      if (in_valid_i === 1'b1 && in_stall_i === 1'b0) absorb_word(in_data_i);
      if (out_valid_i === 1'b1 && out_stall_i === 1'b0) check_digest_word(out_data_i);
    end
    words_pending_o <= digest_words_q.size();
    fail_count_o    <= mismatches;
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message hasher testbench
// Streams directed and random messages through the hasher with random gaps
// and back-pressure; the checker verifies every digest word.
// ----------------------------------------------------------------------------
module tb;

  import sha256_pkg::*;

  // Cycles without any accepted word before the run is declared hung. The
  // slowest legal stretch is a two-block finish or the long receiver hold,
  // well below this.
  localparam int unsigned IdleLimit   = 5000;
  // Length of the one long receiver hold-off, in cycles.
  localparam int unsigned LongHold    = 300;
  // Random stimulus stops once this many message words have been sent.
  localparam int unsigned RandomWords = 210;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall_o;
  sha256_in_t  in_data;
  logic        out_valid_o;
  logic        out_stall;
  sha256_out_t out_data_o;

  int unsigned words_pending;
  int unsigned fail_count;
  int unsigned words_sent;

  // Both sides skip their random gaps while this is set.
  bit quiet;
  // Asks the receiver for one long hold-off.
  bit hold_request;

  sha256_message_hasher i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  sha256_message_hasher_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall_o),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall),
    .out_data_i      (out_data_o),
    .words_pending_o (words_pending),
    .fail_count_o    (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Offers one word after a random gap and holds it until it is taken. Valid
  // is only dropped when a gap follows, so back-to-back words keep it high.
  task automatic send_word(input logic [7:0] data, input logic present,
                           input logic eom);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: data, byte_present: present, end_of_message: eom};
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  // Sends a message of random bytes. It is closed either on its last byte or
  // by a separate byte-less end word, and now and then an ignored word with
  // neither flag is slipped in between the bytes.
  task automatic send_message(input int unsigned len);
    bit end_apart;
    end_apart = (len == 0) || ($urandom_range(0, 2) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_word(8'($urandom), 1'b0, 1'b0);
      send_word(8'($urandom), 1'b1, (i == len - 1) && !end_apart);
    end
    if (end_apart) send_word(8'($urandom), 1'b0, 1'b1);
    words_sent += len + end_apart;
  endtask

  // Stops offering words until every queued digest word has been returned.
  task automatic wait_for_digests();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (words_pending != 0);
  endtask

  // Receiver: a random stall before each digest word, or the long hold-off
  // once it is requested. The hold is counted here, independent of the sender.
  initial begin : receiver
    int unsigned stall_cycles;
    out_stall = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        stall_cycles = LongHold;
        hold_request = 1'b0;
      end else begin
        stall_cycles = quiet ? 0 : $urandom_range(0, 4);
      end
      if (stall_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (stall_cycles) @(posedge clk_i);
        out_stall <= 1'b0;
      end
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  // Watchdog: ends the run if no word moves on either channel for too long.
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    quiet        = 1'b0;
    hold_request = 1'b0;
    words_sent   = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. An end word with no byte closes an empty message, which
    // must give the digest of the empty string.
    send_word(8'h00, 1'b0, 1'b1);
    // Words with neither flag are ignored and produce nothing.
    send_word(8'hff, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b0);
    // The classic three-byte message, closed together with its last byte.
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h63, 1'b1, 1'b1);
    // Single extreme bytes, each closed together with the byte.
    send_word(8'h00, 1'b1, 1'b1);
    send_word(8'hff, 1'b1, 1'b1);
    // Extreme bytes with an ignored word in the middle, closed by a separate
    // end word whose unused data field is all ones.
    send_word(8'hff, 1'b1, 1'b0);
    send_word(8'ha5, 1'b0, 1'b0);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'hff, 1'b0, 1'b1);
    wait_for_digests();

    // Random part. A full block with no gaps on either side: the end padding
    // then fills a block of its own.
    quiet = 1'b1;
    send_message(64);
    quiet = 1'b0;
    // 55 bytes leave just room for the pad byte and length in one block.
    send_message(55);

    // Long receiver hold: the first digest backs up, the hasher stalls its
    // input and the following messages wait at the input.
    hold_request = 1'b1;
    repeat (3) send_message($urandom_range(1, 8));
    wait_for_digests();

    // 56 bytes force a second padding block.
    send_message(56);

    // Mostly short messages for many digests, some longer ones across blocks.
    while (words_sent < RandomWords) begin
      quiet = ($urandom_range(0, 4) == 0);
      send_message(($urandom_range(0, 3) == 0) ? $urandom_range(9, 70)
                                               : $urandom_range(0, 8));
    end
    quiet = 1'b0;

    wait_for_digests();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
